// ----- rtl/tmt_pkg.sv -----
// Shared types and constants of the trapezoid move timing block.
`default_nettype none
package tmt_pkg;

    localparam int LEN_W  = 20;
    localparam int SPD_W  = 17;
    localparam int RATE_W = 16;
    localparam int TIME_W = 40;

    localparam logic [19:0]       US_SCALE = 20'd1000000;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [1:0] REG_TOP   = 2'd0;
    localparam logic [1:0] REG_ACCEL = 2'd1;
    localparam logic [1:0] REG_BRAKE = 2'd2;

    localparam logic [RATE_W-1:0] TOP_RST   = 16'd5000;
    localparam logic [RATE_W-1:0] ACCEL_RST = 16'd2000;
    localparam logic [RATE_W-1:0] BRAKE_RST = 16'd2000;

    // Facts of one segment that ride along the whole pipeline.
    typedef struct packed {
        logic              zero;
        logic [SPD_W-1:0]  zpeak;
        logic [RATE_W-1:0] v0;
        logic [RATE_W-1:0] vf;
    } t_tag;

    typedef struct packed {
        t_tag        tag;
        logic        reach;
        logic [53:0] num;
        logic [48:0] den;
        logic [72:0] pc;
    } t_front;

    typedef struct packed {
        t_tag        tag;
        logic        reach;
        logic [53:0] num;
    } t_sb1;

    typedef struct packed {
        t_tag              tag;
        logic              reach;
        logic [TIME_W-1:0] tc;
    } t_sb2;

    typedef struct packed {
        logic              zero;
        logic [SPD_W-1:0]  zpeak;
        logic              reach;
        logic [RATE_W-1:0] peak;
    } t_sb3;

endpackage
`default_nettype wire

// ----- rtl/tmt_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating on overflow.
`default_nettype none
module tmt_div #(
    parameter int NW = 37,
    parameter int DW = 16,
    parameter int QW = 36,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic [SW-1:0]      o_side
);

    logic [QW:0]   r_v;
    logic          r_ovf  [QW+1];
    logic [DW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_low  [QW+1];
    logic [SW-1:0] r_side [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    // The upper numerator bits seed the remainder; if they already reach the
    // divisor the quotient cannot fit and the result saturates.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= DW'(i_num[NW-1:QW]);
            r_ovf[0]  <= DW'(i_num[NW-1:QW]) >= i_den;
            r_low[0]  <= i_num[QW-1:0];
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] w_trial;
        logic [DW:0] w_diff;
        logic        w_ge;

        assign w_trial = {r_rem[k-1], r_low[k-1][QW-1]};
        assign w_ge    = w_trial >= {1'b0, r_den[k-1]};
        assign w_diff  = w_trial - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_low[k]  <= {r_low[k-1][QW-2:0], w_ge};
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end

        if (k < QW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_ovf[QW] ? {QW{1'b1}} : r_low[QW];
    assign o_side  = r_side[QW];

endmodule
`default_nettype wire

// ----- rtl/tmt_isqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module tmt_isqrt #(
    parameter int NW = 54,
    parameter int SW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [NW-1:0]   i_n,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_valid,
    output logic [NW/2-1:0]      o_root,
    output logic [SW-1:0]        o_side
);

    localparam int RW = NW / 2;

    logic [RW:0]   r_v;
    logic [NW-1:0] r_n    [RW];
    logic [RW+1:0] r_r    [RW];
    logic [RW-1:0] r_q    [RW+1];
    logic [SW-1:0] r_side [RW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]    <= i_n;
            r_r[0]    <= '0;
            r_q[0]    <= '0;
            r_side[0] <= i_side;
        end
    end

    // Each stage brings down two radicand bits and tries the digit 4q+1.
    for (genvar k = 1; k <= RW; k++) begin : g_step
        logic [RW+3:0] w_cur;
        logic [RW+3:0] w_try;
        logic [RW+3:0] w_diff;
        logic          w_ge;

        assign w_cur  = {r_r[k-1], r_n[k-1][NW-1:NW-2]};
        assign w_try  = {2'b00, r_q[k-1], 2'b01};
        assign w_ge   = w_cur >= w_try;
        assign w_diff = w_cur - w_try;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]    <= {r_q[k-1][RW-2:0], w_ge};
                r_side[k] <= r_side[k-1];
            end
        end

        if (k < RW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_r[k] <= w_ge ? w_diff[RW+1:0] : w_cur[RW+1:0];
                    r_n[k] <= {r_n[k-1][NW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_q[RW];
    assign o_side  = r_side[RW];

endmodule
`default_nettype wire

// ----- rtl/tmt_front.sv -----
// Front stages: speed clamping, distance products and the trapezoid test.
`default_nettype none
module tmt_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [tmt_pkg::LEN_W-1:0]   i_len,
    input  wire logic [tmt_pkg::SPD_W-1:0]   i_start,
    input  wire logic [tmt_pkg::SPD_W-1:0]   i_end,
    input  wire logic [tmt_pkg::RATE_W-1:0]  i_top,
    input  wire logic [tmt_pkg::RATE_W-1:0]  i_acc,
    input  wire logic [tmt_pkg::RATE_W-1:0]  i_brk,
    output logic                             o_valid,
    output tmt_pkg::t_front                  o_fo
);

    logic [8:1] r_v;
    tmt_pkg::t_tag r1_tag, r2_tag, r3_tag, r4_tag, r5_tag, r6_tag, r7_tag, r8_tag;
    tmt_pkg::t_tag n_tag;

    logic [19:0] r1_len, r2_len;
    logic [31:0] r2_t2, r2_v02, r2_vf2, r2_ab;
    logic [31:0] r3_d0, r3_df;
    logic [51:0] r3_lab;
    logic [47:0] r3_avf2, r3_bv02, r3_abt;
    logic [47:0] r4_p1, r4_p2;
    logic [52:0] r4_have, r5_have;
    logic [48:0] r4_numx, r5_need;
    logic [48:0] r4_den, r5_den, r6_den, r7_den, r8_den;
    logic [53:0] r5_num, r6_num, r7_num, r8_num;
    logic        r6_reach, r7_reach, r8_reach;
    logic [52:0] r6_diff;
    logic [45:0] r7_ph;
    logic [46:0] r7_pl;
    logic [72:0] r8_pc;

    // Negative speeds clamp to zero, fast ones to top speed.
    function automatic logic [15:0] clamp(input logic [16:0] v, input logic [15:0] t);
        logic [15:0] c;
        if (v[16]) begin
            c = '0;
        end else if (v[15:0] > t) begin
            c = t;
        end else begin
            c = v[15:0];
        end
        return c;
    endfunction

    always_comb begin
        n_tag.zero  = i_len == '0;
        n_tag.zpeak = ($signed(i_start) > $signed(i_end)) ? i_start : i_end;
        n_tag.v0    = clamp(i_start, i_top);
        n_tag.vf    = clamp(i_end, i_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_tag   <= n_tag;
            r1_len   <= i_len;

            r2_tag   <= r1_tag;
            r2_len   <= r1_len;
            r2_t2    <= 32'(i_top) * 32'(i_top);
            r2_v02   <= 32'(r1_tag.v0) * 32'(r1_tag.v0);
            r2_vf2   <= 32'(r1_tag.vf) * 32'(r1_tag.vf);
            r2_ab    <= 32'(i_acc) * 32'(i_brk);

            r3_tag   <= r2_tag;
            r3_d0    <= r2_t2 - r2_v02;
            r3_df    <= r2_t2 - r2_vf2;
            r3_lab   <= 52'(r2_len) * 52'(r2_ab);
            r3_avf2  <= 48'(i_acc) * 48'(r2_vf2);
            r3_bv02  <= 48'(i_brk) * 48'(r2_v02);
            r3_abt   <= 48'(r2_ab) * 48'(i_top);

            r4_tag   <= r3_tag;
            r4_p1    <= 48'(r3_d0) * 48'(i_brk);
            r4_p2    <= 48'(r3_df) * 48'(i_acc);
            r4_have  <= {r3_lab, 1'b0};
            r4_numx  <= 49'(r3_avf2) + 49'(r3_bv02);
            r4_den   <= {r3_abt, 1'b0};

            r5_tag   <= r4_tag;
            r5_need  <= 49'(r4_p1) + 49'(r4_p2);
            r5_num   <= 54'(r4_have) + 54'(r4_numx);
            r5_have  <= r4_have;
            r5_den   <= r4_den;

            r6_tag   <= r5_tag;
            r6_reach <= 53'(r5_need) <= r5_have;
            r6_diff  <= r5_have - 53'(r5_need);
            r6_num   <= r5_num;
            r6_den   <= r5_den;

            // Spare distance times one million, split to keep the multipliers narrow.
            r7_tag   <= r6_tag;
            r7_ph    <= 46'(r6_diff[52:27]) * 46'(tmt_pkg::US_SCALE);
            r7_pl    <= 47'(r6_diff[26:0]) * 47'(tmt_pkg::US_SCALE);
            r7_reach <= r6_reach;
            r7_num   <= r6_num;
            r7_den   <= r6_den;

            r8_tag   <= r7_tag;
            r8_pc    <= {r7_ph, 27'd0} + 73'(r7_pl);
            r8_reach <= r7_reach;
            r8_num   <= r7_num;
            r8_den   <= r7_den;
        end
    end

    assign o_valid    = r_v[8];
    assign o_fo.tag   = r8_tag;
    assign o_fo.reach = r8_reach;
    assign o_fo.num   = r8_num;
    assign o_fo.den   = r8_den;
    assign o_fo.pc    = r8_pc;

endmodule
`default_nettype wire

// ----- rtl/trapezoid_move_timing.sv -----
// Top level of the trapezoid move timing block: registers, pipeline and result stage.
`default_nettype none
// Fully pipelined: one segment word is taken every cycle while the output side is not
// stalled, and each passes 8 front stages, a 41-stage cruise-time divider, a 55-stage divider
// for the triangle peak, a 28-stage square root, two scaling stages, two parallel
// 37-stage phase-time dividers and the output register. The whole pipeline halts while a
// result word waits on the output side. The user must write the registers over the APB
// port only while no segment is in flight; the block itself does not enforce this.
module trapezoid_move_timing (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_psel,
    input  wire logic          i_penable,
    input  wire logic          i_pwrite,
    input  wire logic [3:0]    i_paddr,
    input  wire logic [31:0]   i_pwdata,
    output logic [31:0]        o_prdata,
    output logic               o_pready,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    // seg_length[19:0], start_speed[36:20], end_speed[53:37], zero pad
    input  wire logic [55:0]   i_s_tdata,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    // peak_speed[16:0], accel_time[56:17], cruise_time[96:57], brake_time[136:97],
    // total_time[176:137], zero pad
    output logic [183:0]       o_m_tdata,
    // reaches_top
    output logic               o_m_tuser
);

    logic [15:0] r_top, r_acc, r_brk;
    logic [15:0] w_t, w_a, w_b;
    logic        w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= tmt_pkg::TOP_RST;
            r_acc <= tmt_pkg::ACCEL_RST;
            r_brk <= tmt_pkg::BRAKE_RST;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (i_paddr[3:2])
                tmt_pkg::REG_TOP:   r_top <= i_pwdata[15:0];
                tmt_pkg::REG_ACCEL: r_acc <= i_pwdata[15:0];
                tmt_pkg::REG_BRAKE: r_brk <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            tmt_pkg::REG_TOP:   o_prdata = {16'd0, r_top};
            tmt_pkg::REG_ACCEL: o_prdata = {16'd0, r_acc};
            tmt_pkg::REG_BRAKE: o_prdata = {16'd0, r_brk};
            default:            o_prdata = '0;
        endcase
    end

    assign o_pready = 1'b1;

    // A zero register behaves as one.
    assign w_t = (r_top == '0) ? 16'd1 : r_top;
    assign w_a = (r_acc == '0) ? 16'd1 : r_acc;
    assign w_b = (r_brk == '0) ? 16'd1 : r_brk;

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    logic              w_fv;
    tmt_pkg::t_front   w_fo;
    tmt_pkg::t_sb1     w_sb1_in, w_sb1;
    tmt_pkg::t_sb2     w_sb2_in, w_sb2_d, w_sb2;
    logic              w_cv, w_qv, w_sv, w_av, w_bv;
    logic [39:0]       w_tc;
    logic [53:0]       w_q;
    logic [26:0]       w_root;

    tmt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_len   (i_s_tdata[19:0]),
        .i_start (i_s_tdata[36:20]),
        .i_end   (i_s_tdata[53:37]),
        .i_top   (w_t),
        .i_acc   (w_a),
        .i_brk   (w_b),
        .o_valid (w_fv),
        .o_fo    (w_fo)
    );

    assign w_sb1_in.tag   = w_fo.tag;
    assign w_sb1_in.reach = w_fo.reach;
    assign w_sb1_in.num   = w_fo.num;

    tmt_div #(.NW(73), .DW(49), .QW(40), .SW($bits(tmt_pkg::t_sb1))) u_div_cruise (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_num   (w_fo.pc),
        .i_den   (w_fo.den),
        .i_side  (w_sb1_in),
        .o_valid (w_cv),
        .o_quo   (w_tc),
        .o_side  (w_sb1)
    );

    assign w_sb2_in.tag   = w_sb1.tag;
    assign w_sb2_in.reach = w_sb1.reach;
    assign w_sb2_in.tc    = w_tc;

    tmt_div #(.NW(55), .DW(17), .QW(54), .SW($bits(tmt_pkg::t_sb2))) u_div_peak (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv),
        .i_num   ({1'b0, w_sb1.num}),
        .i_den   (17'(w_a) + 17'(w_b)),
        .i_side  (w_sb2_in),
        .o_valid (w_qv),
        .o_quo   (w_q),
        .o_side  (w_sb2_d)
    );

    tmt_isqrt #(.NW(54), .SW($bits(tmt_pkg::t_sb2))) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_qv),
        .i_n     (w_q),
        .i_side  (w_sb2_d),
        .o_valid (w_sv),
        .o_root  (w_root),
        .o_side  (w_sb2)
    );

    // Peak speed and the speed gained and lost on either side of it.
    logic [15:0]   w_peak, w_rmin, w_da, w_db;
    logic          r_b1_v, r_b2_v;
    logic [15:0]   r_b1_da, r_b1_db;
    logic [35:0]   r_b2_ma, r_b2_mb;
    tmt_pkg::t_sb3 r_b1_sb, r_b2_sb, w_sb3;
    logic [39:0]   r_b1_tc, r_b2_tc, w_tc_d;
    logic [35:0]   w_ta, w_tb;

    assign w_rmin = (w_root > 27'(w_t)) ? w_t : w_root[15:0];
    assign w_peak = w_sb2.reach ? w_t : w_rmin;
    assign w_da   = (w_peak > w_sb2.tag.v0) ? w_peak - w_sb2.tag.v0 : '0;
    assign w_db   = (w_peak > w_sb2.tag.vf) ? w_peak - w_sb2.tag.vf : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
        end else if (w_en) begin
            r_b1_v <= w_sv;
            r_b2_v <= r_b1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_da       <= w_da;
            r_b1_db       <= w_db;
            r_b1_sb.zero  <= w_sb2.tag.zero;
            r_b1_sb.zpeak <= w_sb2.tag.zpeak;
            r_b1_sb.reach <= w_sb2.reach;
            r_b1_sb.peak  <= w_peak;
            r_b1_tc       <= w_sb2.tc;

            r_b2_ma       <= 36'(r_b1_da) * 36'(tmt_pkg::US_SCALE);
            r_b2_mb       <= 36'(r_b1_db) * 36'(tmt_pkg::US_SCALE);
            r_b2_sb       <= r_b1_sb;
            r_b2_tc       <= r_b1_tc;
        end
    end

    tmt_div #(.NW(37), .DW(16), .QW(36), .SW($bits(tmt_pkg::t_sb3))) u_div_accel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b2_v),
        .i_num   ({1'b0, r_b2_ma}),
        .i_den   (w_a),
        .i_side  (r_b2_sb),
        .o_valid (w_av),
        .o_quo   (w_ta),
        .o_side  (w_sb3)
    );

    tmt_div #(.NW(37), .DW(16), .QW(36), .SW(40)) u_div_brake (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b2_v),
        .i_num   ({1'b0, r_b2_mb}),
        .i_den   (w_b),
        .i_side  (r_b2_tc),
        .o_valid (w_bv),
        .o_quo   (w_tb),
        .o_side  (w_tc_d)
    );

    // Result word: cruise time only in a trapezoid, all times zero for a zero length.
    logic [39:0] w_tc_f;
    logic [41:0] w_sum;
    logic [39:0] w_total;
    logic        r_ov;
    logic [183:0] r_odata;
    logic        r_ouser;

    assign w_tc_f  = w_sb3.reach ? w_tc_d : '0;
    assign w_sum   = 42'(w_ta) + 42'(w_tb) + 42'(w_tc_f);
    assign w_total = (w_sum > 42'(tmt_pkg::TIME_MAX)) ? tmt_pkg::TIME_MAX : w_sum[39:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_av && w_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_sb3.zero) begin
                r_ouser <= 1'b0;
                r_odata <= {7'd0, 160'd0, w_sb3.zpeak};
            end else begin
                r_ouser <= w_sb3.reach;
                r_odata <= {7'd0, w_total, 40'(w_tb), w_tc_f, 40'(w_ta),
                            {1'b0, w_sb3.peak}};
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the trapezoid move timing block: directed, register and random segments.
`default_nettype none
module tb_top;

    typedef struct packed {
        logic                       reach;
        logic [tmt_pkg::SPD_W-1:0]  peak;
        logic [tmt_pkg::TIME_W-1:0] ta;
        logic [tmt_pkg::TIME_W-1:0] tc;
        logic [tmt_pkg::TIME_W-1:0] tb;
        logic [tmt_pkg::TIME_W-1:0] tot;
    } t_timing;

    localparam int PIPE_LAT = 172;
    localparam int CYCLE_LIMIT = 600000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_psel = 1'b0;
    logic          i_penable = 1'b0;
    logic          i_pwrite = 1'b0;
    logic [3:0]    i_paddr = '0;
    logic [31:0]   i_pwdata = '0;
    logic [31:0]   o_prdata;
    logic          o_pready;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    // seg_length[19:0], start_speed[36:20], end_speed[53:37], zero pad
    logic [55:0]   i_s_tdata = '0;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    // peak_speed[16:0], accel_time[56:17], cruise_time[96:57], brake_time[136:97],
    // total_time[176:137], zero pad
    logic [183:0]  o_m_tdata;
    // reaches_top
    logic          o_m_tuser;

    trapezoid_move_timing DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [tmt_pkg::RATE_W-1:0] top_reg = tmt_pkg::TOP_RST;
    logic [tmt_pkg::RATE_W-1:0] accel_reg = tmt_pkg::ACCEL_RST;
    logic [tmt_pkg::RATE_W-1:0] brake_reg = tmt_pkg::BRAKE_RST;

    t_timing timing_q[$];
    int      error_count = 0;
    int      segments_sent = 0;
    int      results_seen = 0;
    int      reach_seen = 0;
    int      ready_pct = 100;
    bit      hold_req = 0;
    longint  cycle_count = 0;

    function automatic logic [tmt_pkg::TIME_W-1:0] scaled_quotient(logic [63:0] num,
                                                                  logic [63:0] den);
        logic [127:0] q;
        q = ({64'd0, num} * 128'd1000000) / {64'd0, den};
        return (q > {88'd0, tmt_pkg::TIME_MAX}) ? tmt_pkg::TIME_MAX
                                                : q[tmt_pkg::TIME_W-1:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] cand;
        res = 0;
        for (int i = 31; i >= 0; i--) begin
            cand = res | (64'd1 << i);
            if (cand * cand <= n) res = cand;
        end
        return res;
    endfunction

    function automatic logic [tmt_pkg::TIME_W-1:0] sat_sum(logic [tmt_pkg::TIME_W-1:0] x,
                                                          logic [tmt_pkg::TIME_W-1:0] y);
        logic [tmt_pkg::TIME_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[tmt_pkg::TIME_W] ? tmt_pkg::TIME_MAX : s[tmt_pkg::TIME_W-1:0];
    endfunction

    function automatic t_timing predict_timing(logic [tmt_pkg::LEN_W-1:0] len,
                                               logic signed [tmt_pkg::SPD_W-1:0] raw0,
                                               logic signed [tmt_pkg::SPD_W-1:0] rawf);
        t_timing r;
        logic [63:0] t, a, b, v0, vf, need, have, num, pk;
        r = '0;
        if (len == 0) begin
            r.peak = (raw0 > rawf) ? raw0 : rawf;
            return r;
        end
        t = (top_reg != 0) ? 64'(top_reg) : 64'd1;
        a = (accel_reg != 0) ? 64'(accel_reg) : 64'd1;
        b = (brake_reg != 0) ? 64'(brake_reg) : 64'd1;
        v0 = (raw0 < 0) ? 64'd0 : (64'(raw0) > t) ? t : 64'(raw0);
        vf = (rawf < 0) ? 64'd0 : (64'(rawf) > t) ? t : 64'(rawf);
        need = (t * t - v0 * v0) * b + (t * t - vf * vf) * a;
        have = 64'd2 * 64'(len) * a * b;
        if (need <= have) begin
            r.reach = 1'b1;
            pk = t;
            r.ta = scaled_quotient(t - v0, a);
            r.tb = scaled_quotient(t - vf, b);
            r.tc = scaled_quotient(have - need, 64'd2 * a * b * t);
        end else begin
            num = have + a * vf * vf + b * v0 * v0;
            pk = int_sqrt(num / (a + b));
            if (pk > t) pk = t;
            r.ta = (pk > v0) ? scaled_quotient(pk - v0, a) : '0;
            r.tb = (pk > vf) ? scaled_quotient(pk - vf, b) : '0;
        end
        r.peak = pk[tmt_pkg::SPD_W-1:0];
        r.tot = sat_sum(sat_sum(r.ta, r.tc), r.tb);
        return r;
    endfunction

    task automatic send_segment(logic [tmt_pkg::LEN_W-1:0] len, logic [tmt_pkg::SPD_W-1:0] s0,
                                logic [tmt_pkg::SPD_W-1:0] sf);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {2'b00, sf, s0, len};
        do @(posedge i_clk); while (!o_s_tready);
        timing_q.push_back(predict_timing(len, s0, sf));
        segments_sent++;
    endtask

    task automatic idle_sender(int n);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Waits for every expected word, then lets the pipeline run empty.
    task automatic drain();
        idle_sender(1);
        while (timing_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    task automatic apb_write(int idx, logic [31:0] val);
        @(negedge i_clk);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= 4'(idx * 4);
        i_pwdata <= val;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        case (idx)
            tmt_pkg::REG_TOP:   top_reg = val[15:0];
            tmt_pkg::REG_ACCEL: accel_reg = val[15:0];
            tmt_pkg::REG_BRAKE: brake_reg = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
    endtask

    task automatic set_rates(logic [15:0] t, logic [15:0] a, logic [15:0] b);
        apb_write(tmt_pkg::REG_TOP, {16'($urandom_range(0, 65535)), t});
        apb_write(tmt_pkg::REG_ACCEL, {16'd0, a});
        apb_write(tmt_pkg::REG_BRAKE, {16'd0, b});
    endtask

    // Mostly well-formed speeds from zero to just past the top speed; a quarter use arbitrary bit patterns.
    task automatic send_random(int n, int gap_pct);
        logic [tmt_pkg::LEN_W-1:0] len;
        logic [tmt_pkg::SPD_W-1:0] s0, sf;
        int lim;
        for (int i = 0; i < n; i++) begin
            lim = (top_reg == 0) ? 2 : int'(top_reg) + 2;
            case ($urandom_range(0, 3))
                0: len = 20'($urandom_range(0, 1048575));
                1: len = 20'($urandom_range(0, 63));
                2: len = 20'($urandom_range(0, 4095));
                default: len = 20'($urandom_range(0, 65535));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                s0 = 17'($urandom());
                sf = 17'($urandom());
            end else begin
                s0 = 17'($urandom_range(0, lim));
                sf = 17'($urandom_range(0, lim));
            end
            send_segment(len, s0, sf);
            if ($urandom_range(0, 99) < gap_pct) idle_sender($urandom_range(1, 6));
        end
    endtask

    task automatic test_directed();
        ready_pct = 100;
        send_segment(20'd0, -17'sd300, 17'sd200);
        send_segment(20'd0, 17'sd65535, -17'sd65535);
        send_segment(20'd0, 17'h10000, 17'h10000);
        send_segment(20'd1048575, 17'sd0, 17'sd0);
        send_segment(20'd1048575, 17'sd65535, 17'sd65535);
        send_segment(20'd1048575, -17'sd65535, -17'sd1);
        send_segment(20'd1, 17'sd0, 17'sd0);
        send_segment(20'd1, 17'sd4999, 17'sd0);
        send_segment(20'd1, 17'sd0, 17'sd5000);
        send_segment(20'd2, 17'sd4990, 17'sd10);
        // Exactly on the trapezoid boundary: 2*L*a*b equals the phase distances.
        send_segment(20'd12500, 17'sd0, 17'sd0);
        send_segment(20'd12499, 17'sd0, 17'sd0);
        send_segment(20'd6250, 17'sd0, 17'sd5000);
        send_segment(20'd100, 17'sd3000, 17'sd9000);
        send_segment(20'd5000, -17'sd20, 17'sd0);
        send_segment(20'd777, 17'sd1234, 17'sd4321);
        drain();
    endtask

    task automatic test_register_extremes();
        ready_pct = 60;
        set_rates(16'd1, 16'd1, 16'd1);
        send_segment(20'd1048575, 17'sd0, 17'sd0);
        send_random(20, 30);
        drain();
        set_rates(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_segment(20'd1048575, 17'sd0, 17'sd0);
        send_random(20, 30);
        drain();
        // Zero rates behave as one.
        set_rates(16'd0, 16'd0, 16'd0);
        send_random(20, 30);
        drain();
        set_rates(16'hFFFF, 16'd1, 16'd1);
        send_random(20, 30);
        drain();
        set_rates(16'd1, 16'hFFFF, 16'hFFFF);
        send_random(20, 30);
        drain();
        // A write past the last register must leave the rates alone.
        set_rates(16'd3000, 16'd500, 16'd9000);
        apb_write(3, 32'h0000_0001);
        send_random(20, 30);
        drain();
    endtask

    task automatic test_random_rates();
        for (int p = 0; p < 6; p++) begin
            ready_pct = $urandom_range(30, 100);
            set_rates(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                      16'($urandom_range(1, 65535)));
            send_random(250, (p == 2) ? 0 : 25);
            drain();
        end
    endtask

    task automatic test_backpressure();
        ready_pct = 80;
        set_rates(16'd5000, 16'd2000, 16'd2000);
        hold_req = 1;
        send_random(300, 0);
        drain();
    endtask

    // The receiver stalls at random, with a long hold-off when asked.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_timing exp_w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (timing_q.size() == 0) begin
                $error("result word with nothing expected");
                error_count++;
            end else begin
                exp_w = timing_q.pop_front();
                if (exp_w.reach) reach_seen++;
                if (o_m_tuser !== exp_w.reach) begin
                    $error("reaches_top: expected %0d, got %0d", exp_w.reach, o_m_tuser);
                    error_count++;
                end
                if (o_m_tdata[16:0] !== exp_w.peak) begin
                    $error("peak_speed: expected %0h, got %0h", exp_w.peak, o_m_tdata[16:0]);
                    error_count++;
                end
                if (o_m_tdata[56:17] !== exp_w.ta) begin
                    $error("accel_time: expected %0d, got %0d", exp_w.ta, o_m_tdata[56:17]);
                    error_count++;
                end
                if (o_m_tdata[96:57] !== exp_w.tc) begin
                    $error("cruise_time: expected %0d, got %0d", exp_w.tc, o_m_tdata[96:57]);
                    error_count++;
                end
                if (o_m_tdata[136:97] !== exp_w.tb) begin
                    $error("brake_time: expected %0d, got %0d", exp_w.tb, o_m_tdata[136:97]);
                    error_count++;
                end
                if (o_m_tdata[176:137] !== exp_w.tot) begin
                    $error("total_time: expected %0d, got %0d", exp_w.tot, o_m_tdata[176:137]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[trapezoid_move_timing] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_register_extremes();
        test_random_rates();
        test_backpressure();
        drain();
        if (timing_q.size() != 0) begin
            $error("%0d expected words never arrived", timing_q.size());
            error_count++;
        end
        $display("Sent %0d segments over a dozen rate settings; %0d result words checked,",
                 segments_sent, results_seen);
        $display("%0d of them with a cruise phase, %0d mismatches.", reach_seen, error_count);
        if (error_count == 0) begin
            $display("[trapezoid_move_timing] OK");
        end else begin
            $display("[trapezoid_move_timing] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
